// ===== src/gbn_pkg.sv =====
package gbn_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int WINDOW_MAX   = 32;
   localparam int SLOT_W  = $clog2(BUFFER_DEPTH);
   localparam int COUNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LENGTH = 1'd1;

   localparam logic [1:0] OP_NEW    = 2'd0;
   localparam logic [1:0] OP_ACK    = 2'd1;
   localparam logic [1:0] OP_EXPIRE = 2'd2;

   localparam logic [1:0] TMR_NONE  = 2'd0;
   localparam logic [1:0] TMR_START = 2'd1;
   localparam logic [1:0] TMR_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] payload_low;
      logic [63:0] payload_mid;
      logic [31:0] payload_high;
      logic [31:0] ack_number;
      logic [31:0] ack_sequence;
      logic [31:0] ack_checksum;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [31:0] sequence_out;
      logic [63:0] out_payload_low;
      logic [63:0] out_payload_mid;
      logic [31:0] out_payload_high;
      logic [31:0] packet_checksum;
      logic [1:0]  timer_command;
      logic [15:0] timer_length;
      logic        dropped;
      logic        last;
   } rsp_type;

   // job handed from front to back
   typedef struct packed {
      logic              replay;      // read ring for a run of packets
      logic              write;       // store payload at slot
      logic [SLOT_W-1:0] slot;
      logic [31:0]       seq;
      logic [WIN_W-1:0]  count;       // packets in replay run
      logic [63:0]       lo;
      logic [63:0]       mid;
      logic [31:0]       hi;
      rsp_type           rsp;         // result for non-replay jobs; timer fields of replay jobs
   } job_type;

   function automatic logic [31:0] byte_sum(input logic [63:0] v);
      logic [31:0] s;
      s = '0;
      for (int i = 0; i < 8; i++) s = s + {24'd0, v[8*i +: 8]};
      return s;
   endfunction

endpackage

// ===== src/gbn_front.sv =====
module gbn_front import gbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_word,
   output logic                  job_valid,
   output job_type               job_word,
   input  logic                  job_full
);

   logic [5:0]         win_ff;
   logic [15:0]        tmo_ff;
   logic [31:0]        base_ff, base_in;
   logic [31:0]        nseq_ff, nseq_in;
   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [WIN_W-1:0]   eff_win;
   logic [31:0]        ack_off;
   logic               take;
   job_type            job;

   assign req_full  = job_full;
   assign take      = req_push && !job_full;
   assign job_valid = take;
   assign job_word  = job;

   // window clamp
   always_comb begin
      if (win_ff == 6'd0) eff_win = WIN_W'(1);
      else if (32'(win_ff) > 32'(WINDOW_MAX)) eff_win = WIN_W'(WINDOW_MAX);
      else eff_win = WIN_W'(win_ff);
   end

   assign ack_off = req_word.ack_number - base_ff;

   // classify and update window state
   always_comb begin
      base_in = base_ff;
      nseq_in = nseq_ff;
      head_in = head_ff;
      cnt_in  = cnt_ff;
      job     = '0;
      job.rsp.last = 1'b1;
      job.lo  = req_word.payload_low;
      job.mid = req_word.payload_mid;
      job.hi  = req_word.payload_high;
      job.seq = nseq_ff;
      job.slot = SLOT_W'(32'(head_ff) + 32'(cnt_ff));
      unique case (req_word.operation)
         OP_NEW: begin
            if (32'(cnt_ff) >= 32'(BUFFER_DEPTH)) begin
               job.rsp.dropped = 1'b1;
            end else begin
               job.write = 1'b1;
               if (32'(cnt_ff) < 32'(eff_win)) begin
                  job.replay = 1'b1;
                  job.count  = WIN_W'(1);
                  if (cnt_ff == '0) begin
                     job.rsp.timer_command = TMR_START;
                     job.rsp.timer_length  = tmo_ff;
                  end
               end
               cnt_in  = cnt_ff + COUNT_W'(1);
               nseq_in = nseq_ff + 32'd1;
            end
         end
         OP_ACK: begin
            if (req_word.ack_sequence + req_word.ack_number == req_word.ack_checksum &&
                ack_off < 32'(cnt_ff)) begin
               base_in = req_word.ack_number + 32'd1;
               head_in = SLOT_W'(32'(head_ff) + ack_off + 32'd1);
               cnt_in  = COUNT_W'(32'(cnt_ff) - ack_off - 32'd1);
               if (cnt_in == '0) begin
                  job.rsp.timer_command = TMR_STOP;
               end else begin
                  job.rsp.timer_command = TMR_START;
                  job.rsp.timer_length  = tmo_ff;
               end
            end
         end
         OP_EXPIRE: begin
            if (cnt_ff != '0) begin
               job.replay = 1'b1;
               job.seq    = base_ff;
               job.slot   = head_ff;
               job.count  = (32'(cnt_ff) > 32'(eff_win)) ? eff_win : WIN_W'(cnt_ff);
               job.rsp.timer_command = TMR_START;
               job.rsp.timer_length  = tmo_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= 6'd8;
         tmo_ff  <= 16'd50;
         base_ff <= '0;
         nseq_ff <= '0;
         head_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (csr_write && csr_index == CSR_WINDOW_SIZE)    win_ff <= csr_data[5:0];
         if (csr_write && csr_index == CSR_TIMEOUT_LENGTH) tmo_ff <= csr_data;
         if (take) begin
            base_ff <= base_in;
            nseq_ff <= nseq_in;
            head_ff <= head_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

endmodule

// ===== src/gbn_queue.sv =====
module gbn_queue import gbn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_full,
   input  job_type in_word,
   output logic    out_valid,
   input  logic    out_take,
   output job_type out_word
);

   // two-entry job queue
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] n_ff;

   assign in_full   = n_ff == 2'd2;
   assign out_valid = n_ff != 2'd0;
   assign out_word  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (in_valid && !in_full) mem_ff[wp_ff] <= in_word;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         if (in_valid && !in_full) wp_ff <= !wp_ff;
         if (out_take && out_valid) rp_ff <= !rp_ff;
         n_ff <= n_ff + 2'(in_valid && !in_full) - 2'(out_take && out_valid);
      end
   end

endmodule

// ===== src/gbn_back.sv =====
module gbn_back import gbn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_take,
   input  job_type job_word,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_word
);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_SUM} state_type;

   logic [63:0] ring_low  [BUFFER_DEPTH];
   logic [63:0] ring_mid  [BUFFER_DEPTH];
   logic [31:0] ring_high [BUFFER_DEPTH];

   state_type         state_ff;
   job_type           cur_ff;
   logic [WIN_W-1:0]  idx_ff;
   logic [63:0]       rd_lo_ff, rd_mid_ff;
   logic [31:0]       rd_hi_ff;
   logic [31:0]       seq_ff;
   logic              out_ok_ff, out_ok_in;
   rsp_type           out_ff;
   rsp_type           pkt;
   logic              fin;
   logic              out_free;

   assign rsp_empty = !out_ok_ff;
   assign rsp_word  = out_ff;
   assign out_free  = !out_ok_ff || rsp_pop;
   assign job_take  = state_ff == S_IDLE && job_valid && out_free;
   assign fin       = idx_ff + WIN_W'(1) == cur_ff.count;

   // packet word built from the registered ring read
   always_comb begin
      pkt = '0;
      pkt.send_valid       = 1'b1;
      pkt.sequence_out     = seq_ff;
      pkt.out_payload_low  = rd_lo_ff;
      pkt.out_payload_mid  = rd_mid_ff;
      pkt.out_payload_high = rd_hi_ff;
      pkt.packet_checksum  = seq_ff + seq_ff + byte_sum(rd_lo_ff)
         + byte_sum(rd_mid_ff) + byte_sum({32'd0, rd_hi_ff});
      if (fin) begin
         pkt.timer_command = cur_ff.rsp.timer_command;
         pkt.timer_length  = cur_ff.rsp.timer_length;
         pkt.last          = 1'b1;
      end
   end

   // output register fill and drain
   always_comb begin
      if ((state_ff == S_IDLE && job_take && !job_word.replay) ||
          (state_ff == S_SUM && out_free)) out_ok_in = 1'b1;
      else out_ok_in = out_ok_ff && !rsp_pop;
   end

   // ring writes and registered reads
   always_ff @(posedge clock) begin
      if (job_take && job_word.write) begin
         ring_low[job_word.slot]  <= job_word.lo;
         ring_mid[job_word.slot]  <= job_word.mid;
         ring_high[job_word.slot] <= job_word.hi;
      end
      rd_lo_ff  <= ring_low[SLOT_W'(32'(cur_ff.slot) + 32'(idx_ff))];
      rd_mid_ff <= ring_mid[SLOT_W'(32'(cur_ff.slot) + 32'(idx_ff))];
      rd_hi_ff  <= ring_high[SLOT_W'(32'(cur_ff.slot) + 32'(idx_ff))];
      seq_ff    <= cur_ff.seq + 32'(idx_ff);
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         out_ok_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         out_ok_ff <= out_ok_in;
         unique case (state_ff)
            S_IDLE: begin
               if (job_take) begin
                  cur_ff <= job_word;
                  idx_ff <= '0;
                  if (job_word.replay) begin
                     state_ff <= S_READ;
                  end else begin
                     out_ff <= job_word.rsp;
                  end
               end
            end
            S_READ: state_ff <= S_SUM;
            S_SUM: begin
               if (out_free) begin
                  out_ff <= pkt;
                  if (fin) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + WIN_W'(1);
                     state_ff <= S_READ;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/go_back_n_sender.sv =====
// Go-Back-N sender.
// Input channel (req_push/req_full/req_word): one word per operation: new
// message, arriving ack, or timer expiry. Result channel
// (rsp_empty/rsp_pop/rsp_word): one or more result words per operation, the
// final one flagged by last.
// csr_write/csr_index/csr_data set window_size (index 0) and timeout_length
// (index 1); write them only while the block is idle.
// The front tracks base, next sequence and ring occupancy and accepts a word
// every cycle while its two-entry job queue has room. The back owns the
// 64-slot payload ring. An ack, a drop or an unsent message that it takes
// puts its result into the output register at the edge that takes it; a
// sent message goes out as one packet and an expiry resends its run, each
// packet passing a ring read, then a checksum into the output register.
// The back takes no new job until the last packet of a run has gone out;
// acks, drops and unsent messages are taken back to back while popped.
// Reset (synchronous, active high) restores window 8, timeout 50 and an
// empty ring; ring contents are not cleared.
// When the receiver stops popping, the output register holds, the back
// stalls, the queue fills and req_full rises; nothing is lost.
module go_back_n_sender import gbn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_word,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_word
);

   logic    fq_valid, fq_full, qb_valid, qb_take;
   job_type fq_word, qb_word;

   gbn_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req_push, .req_full, .req_word,
      .job_valid(fq_valid), .job_word(fq_word), .job_full(fq_full)
   );

   gbn_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_full(fq_full), .in_word(fq_word),
      .out_valid(qb_valid), .out_take(qb_take), .out_word(qb_word)
   );

   gbn_back u_back (
      .clock, .reset,
      .job_valid(qb_valid), .job_take(qb_take), .job_word(qb_word),
      .rsp_empty, .rsp_pop, .rsp_word
   );

endmodule

// ===== src/gbn_checker.sv =====
module gbn_checker import gbn_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_word
);

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("result word changed while stalled");

   // a drop is never a send, and is final
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.dropped) |-> (!rsp_word.send_valid && rsp_word.last))
      else $error("drop result malformed");

   // timer command only on final word
   a_tmr: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.timer_command != TMR_NONE) |-> rsp_word.last)
      else $error("timer command before last word");

   // nothing to send after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result after reset");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_word
);
